// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top-level RTL file of the hit detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/mthd_pkg.sv -----
// ----------------------------------------------------------------------------
// mthd_pkg
// Types and fixed constants of the median threshold hit detector.
// ----------------------------------------------------------------------------
package mthd_pkg;

    localparam int PORT_CHANNELS   = 10;
    localparam int PORT_POWER_BITS = 32;
    localparam int FACTOR_BITS     = 8;
    localparam int COUNT_BITS      = 16;
    localparam int CH_IDX_BITS     = 4;

    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 8'd5;

    // Input word layout.
    localparam int S_LOCK_BIT   = PORT_CHANNELS * PORT_POWER_BITS;
    localparam int S_CLEAR_BIT  = S_LOCK_BIT + 1;
    localparam int S_TDATA_BITS = ((S_CLEAR_BIT + 1 + 7) / 8) * 8;

    // Output word layout.
    localparam int M_HIT_NOW_BIT  = 0;
    localparam int M_HIT_FLAG_BIT = 1;
    localparam int M_CH_LSB       = 2;
    localparam int M_COUNT_LSB    = M_CH_LSB + CH_IDX_BITS;
    localparam int M_MEDIAN_LSB   = M_COUNT_LSB + COUNT_BITS;
    localparam int M_USED_BITS    = M_MEDIAN_LSB + PORT_POWER_BITS;
    localparam int M_TDATA_BITS   = ((M_USED_BITS + 7) / 8) * 8;

    typedef logic [S_TDATA_BITS-1:0] s_word_t;
    typedef logic [M_TDATA_BITS-1:0] m_word_t;
    typedef logic [COUNT_BITS-1:0]   count_t;

    // Per-frame update request to the hit counters.
    typedef struct packed {
        logic valid;
        logic clear;
        logic hit;
    } upd_t;

    // State read back after the update.
    typedef struct packed {
        logic   hit_flag;
        count_t count;
    } stat_t;

endpackage

// ----- sv/mthd_select.sv -----
// ----------------------------------------------------------------------------
// mthd_select
// Finds the median and the lowest-indexed maximum of one frame by parallel
// ranking, and compares the maximum against the scaled median.
// ----------------------------------------------------------------------------
module mthd_select #(
    parameter int CHANNELS   = 10,
    parameter int MEDIAN_POS = 4,
    parameter int PW         = 32,
    parameter int CW         = 4
) (
    input  logic [mthd_pkg::PORT_CHANNELS*mthd_pkg::PORT_POWER_BITS-1:0] powers,
    input  logic [mthd_pkg::FACTOR_BITS-1:0]                             factor,
    output logic [PW-1:0]                                                median,
    output logic [CW-1:0]                                                max_ch,
    output logic                                                         above
);
    import mthd_pkg::*;

    localparam int RW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MPOS = (MEDIAN_POS < CHANNELS) ? MEDIAN_POS : CHANNELS - 1;
    localparam int TW   = PW + FACTOR_BITS;

    logic [PW-1:0]       pw [CHANNELS];
    logic [RW-1:0]       rank [CHANNELS];
    logic [CHANNELS-1:0] is_max;
    logic [PW-1:0]       max_val;
    logic [TW-1:0]       thr;

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            pw[i] = powers[i*PORT_POWER_BITS +: PW];
        end
    end

    always_comb
    begin
        logic [RW-1:0] r;
        r = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            r = '0;
            for (int j = 0; j < CHANNELS; j++)
            begin
                if (j != i)
                begin
                    if ((pw[j] < pw[i]) || ((pw[j] == pw[i]) && (j < i)))
                    begin
                        r = r + 1'b1;
                    end
                end
            end
            rank[i] = r;
        end
    end

    always_comb
    begin
        median = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (rank[i] == RW'(MPOS))
            begin
                median = median | pw[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            is_max[i] = 1'b1;
            for (int j = 0; j < CHANNELS; j++)
            begin
                if (pw[j] > pw[i])
                begin
                    is_max[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        max_ch  = '0;
        max_val = pw[0];
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (is_max[i])
            begin
                max_ch  = CW'(i);
                max_val = pw[i];
            end
        end
    end

    assign thr   = TW'(median) * TW'(factor);
    assign above = TW'(max_val) > thr;

endmodule

// ----- sv/mthd_counts.sv -----
// ----------------------------------------------------------------------------
// mthd_counts
// Per-channel saturating hit counters and the sticky hit flag.
// ----------------------------------------------------------------------------
module mthd_counts #(
    parameter int CHANNELS = 10,
    parameter int CW       = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mthd_pkg::upd_t upd,
    input  logic [CW-1:0]  ch,
    output mthd_pkg::stat_t stat
);
    import mthd_pkg::*;

    count_t count_reg [CHANNELS];
    count_t count_next;
    logic   flag_reg;
    logic   flag_next;
    count_t cur;

    always_comb
    begin
        cur = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (ch == CW'(i))
            begin
                cur = count_reg[i];
            end
        end
        count_next = (upd.hit && (cur != '1)) ? cur + 1'b1 : cur;
        flag_next  = (flag_reg && !upd.clear) || upd.hit;
    end

    assign stat.hit_flag = flag_next;
    assign stat.count    = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (upd.valid)
        begin
            flag_reg <= flag_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (ch == CW'(i))
                begin
                    count_reg[i] <= count_next;
                end
            end
        end
    end

endmodule

// ----- sv/median_threshold_hit_detector.sv -----
// ----------------------------------------------------------------------------
// median_threshold_hit_detector
// Flags frames whose peak channel power exceeds a multiple of the median.
// ----------------------------------------------------------------------------
// The block takes one frame word per clock and returns one result word per
// frame: an input register feeds a single pass of parallel ranking compares,
// one median-by-factor multiply and the counter update, which lands in the
// result register. Throughput is one frame per cycle as long as the result side
// takes words. The user must write the threshold factor over the configuration
// channel only while no frame is in flight; the block does not enforce this.
module median_threshold_hit_detector #(
    parameter int CHANNELS   = 10,
    parameter int MEDIAN_POS = 4,
    parameter int POWER_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // power_ch0..power_ch9 (32 bits each), lockout_active, clear_hit, zero pad
    input  logic [mthd_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit_now, hit_flag, max_channel (4), max_channel_count (16),
    // median_power (32), zero pad
    output logic [mthd_pkg::M_TDATA_BITS-1:0] m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mthd_pkg::FACTOR_BITS-1:0]  cfg_data
);
    import mthd_pkg::*;
    `include "assert_macros.svh"

    localparam int PW = (POWER_BITS < PORT_POWER_BITS) ? POWER_BITS : PORT_POWER_BITS;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                     in_valid_reg;
    s_word_t                  in_data_reg;
    logic                     out_valid_reg;
    m_word_t                  out_data_reg;
    m_word_t                  out_data_next;
    logic [FACTOR_BITS-1:0]   factor_reg;
    logic                     advance;
    logic [PW-1:0]            median;
    logic [CW-1:0]            max_ch;
    logic                     above;
    upd_t                     upd;
    stat_t                    stat;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    mthd_select #(
        .CHANNELS   (CHANNELS),
        .MEDIAN_POS (MEDIAN_POS),
        .PW         (PW),
        .CW         (CW)
    ) u_select (
        .powers (in_data_reg[S_LOCK_BIT-1:0]),
        .factor (factor_reg),
        .median (median),
        .max_ch (max_ch),
        .above  (above)
    );

    assign upd.valid = advance;
    assign upd.clear = in_data_reg[S_CLEAR_BIT];
    assign upd.hit   = advance && !in_data_reg[S_LOCK_BIT] && above;

    mthd_counts #(
        .CHANNELS (CHANNELS),
        .CW       (CW)
    ) u_counts (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .ch    (max_ch),
        .stat  (stat)
    );

    always_comb
    begin
        out_data_next = '0;
        out_data_next[M_HIT_NOW_BIT]  = upd.hit;
        out_data_next[M_HIT_FLAG_BIT] = stat.hit_flag;
        out_data_next[M_CH_LSB +: CH_IDX_BITS]       = CH_IDX_BITS'(max_ch);
        out_data_next[M_COUNT_LSB +: COUNT_BITS]     = stat.count;
        out_data_next[M_MEDIAN_LSB +: PORT_POWER_BITS] = PORT_POWER_BITS'(median);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            factor_reg    <= FACTOR_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                factor_reg <= cfg_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `ASSERT_IMPLIES(a_hit_sets_flag, clk, rst_n,
        m_tvalid && m_tdata[M_HIT_NOW_BIT], m_tdata[M_HIT_FLAG_BIT])
    `ASSERT_IMPLIES(a_hit_count_nonzero, clk, rst_n,
        m_tvalid && m_tdata[M_HIT_NOW_BIT], m_tdata[M_COUNT_LSB +: COUNT_BITS] != '0)
    `ASSERT_IMPLIES(a_channel_in_range, clk, rst_n,
        m_tvalid, m_tdata[M_CH_LSB +: CH_IDX_BITS] < CH_IDX_BITS'(CHANNELS))
    `ASSERT_NEXT(a_advance_fills_output, clk, rst_n,
        advance, out_valid_reg)

endmodule

// ----- tb/tb_median_threshold_hit_detector.sv -----
// ----------------------------------------------------------------------------
// tb_median_threshold_hit_detector
// Self-checking testbench of the median threshold hit detector.
// ----------------------------------------------------------------------------
// Frames are driven on the input stream and every result word is checked
// field by field against a predictor kept in step with the block. A short
// directed list comes first. After it come random phases, each under its own
// threshold factor, with idle gaps on both sides, then a streak of frames that
// all hit on one channel and a last random run. One phase stalls the result side
// for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_median_threshold_hit_detector;

    import mthd_pkg::*;

    localparam int MEDIAN_RANK     = 4;
    localparam int PHASE_ITEMS     = 170;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SAT_CHANNEL     = 5;
    localparam int STREAK_ITEMS    = 40;
    localparam int COUNT_FULL      = 65535;

    typedef bit [31:0] power_t;
    typedef bit [PORT_CHANNELS-1:0][31:0] powers_t;

    typedef struct {
        powers_t power;
        bit      lockout;
        bit      clear;
    } frame_t;

    typedef struct {
        bit         hit_now;
        bit         hit_flag;
        bit [3:0]   max_channel;
        bit [15:0]  max_channel_count;
        bit [31:0]  median_power;
    } report_t;

    typedef struct {
        frame_t  frame;
        bit      known;
        report_t want;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    s_word_t           s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    m_word_t           m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [FACTOR_BITS-1:0] cfg_data;

    bit [7:0]  gain;
    bit [15:0] chan_hits [PORT_CHANNELS];
    bit        sticky_flag;
    report_t   pending_reports [$];
    int        mismatches;
    bit        send_gaps_on;
    bit        recv_gaps_on;
    bit        hold_off_pending;
    int        quiet_cycles;

    median_threshold_hit_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic powers_t sort_powers(powers_t p);
        power_t key;
        int     j;
        for (int i = 1; i < PORT_CHANNELS; i++)
        begin
            key = p[i];
            j = i;
            while (j > 0 && p[j-1] > key)
            begin
                p[j] = p[j-1];
                j--;
            end
            p[j] = key;
        end
        return p;
    endfunction

    // Advances the detector state by one frame and returns the report it gives.
    function automatic report_t judge_frame(frame_t f);
        powers_t  sorted;
        power_t   peak;
        bit [39:0] threshold;
        int       peak_ch;
        bit       hit;
        report_t  r;
        sorted = sort_powers(f.power);
        peak = sorted[PORT_CHANNELS-1];
        threshold = {8'd0, sorted[MEDIAN_RANK]} * {32'd0, gain};
        peak_ch = 0;
        for (int i = PORT_CHANNELS - 1; i >= 0; i--)
        begin
            if (f.power[i] == peak)
                peak_ch = i;
        end
        if (f.clear)
            sticky_flag = 1'b0;
        hit = !f.lockout && ({8'd0, peak} > threshold);
        if (hit)
        begin
            sticky_flag = 1'b1;
            if (chan_hits[peak_ch] != 16'(COUNT_FULL))
                chan_hits[peak_ch]++;
        end
        r.hit_now = hit;
        r.hit_flag = sticky_flag;
        r.max_channel = 4'(peak_ch);
        r.max_channel_count = chan_hits[peak_ch];
        r.median_power = sorted[MEDIAN_RANK];
        return r;
    endfunction

    function automatic frame_t flat_frame(power_t base, int ch_a, power_t val_a,
                                          int ch_b, power_t val_b, bit lock, bit clr);
        frame_t f;
        for (int i = 0; i < PORT_CHANNELS; i++)
            f.power[i] = base;
        f.power[ch_a] = val_a;
        f.power[ch_b] = val_b;
        f.lockout = lock;
        f.clear = clr;
        return f;
    endfunction

    function automatic row_t row(frame_t f, bit known, report_t want);
        row_t r;
        r.frame = f;
        r.known = known;
        r.want = want;
        return r;
    endfunction

    function automatic frame_t draw_frame();
        frame_t      f;
        powers_t     sorted;
        longint      target;
        int unsigned top;
        int          k;
        power_t      base;
        f.lockout = ($urandom_range(0, 3) == 0);
        f.clear = ($urandom_range(0, 6) == 0);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                for (int i = 0; i < PORT_CHANNELS; i++)
                    f.power[i] = $urandom;
            end
            2, 3, 4, 5, 6:
            begin
                // A noise floor with a spike placed right around the threshold.
                case ($urandom_range(0, 3))
                    0: top = 15;
                    1: top = 4095;
                    2: top = 32'h00FF_FFFF;
                    default: top = 32'h7FFF_FFFF;
                endcase
                for (int i = 0; i < PORT_CHANNELS; i++)
                    f.power[i] = $urandom_range(0, top);
                sorted = sort_powers(f.power);
                target = longint'(sorted[MEDIAN_RANK]) * longint'(gain)
                         + longint'($urandom_range(0, 4)) - 2;
                if (target < 0)
                    target = 0;
                if (target > longint'(32'hFFFF_FFFF))
                    target = longint'(32'hFFFF_FFFF);
                k = $urandom_range(0, PORT_CHANNELS - 1);
                f.power[k] = target[31:0];
                if ($urandom_range(0, 3) == 0)
                    f.power[$urandom_range(0, PORT_CHANNELS - 1)] = target[31:0];
            end
            7:
            begin
                for (int i = 0; i < PORT_CHANNELS; i++)
                begin
                    case ($urandom_range(0, 4))
                        0: f.power[i] = 32'h0000_0000;
                        1: f.power[i] = 32'h0000_0001;
                        2: f.power[i] = 32'h7FFF_FFFF;
                        3: f.power[i] = 32'h8000_0000;
                        default: f.power[i] = 32'hFFFF_FFFF;
                    endcase
                end
            end
            default:
            begin
                base = $urandom;
                for (int i = 0; i < PORT_CHANNELS; i++)
                    f.power[i] = base + power_t'($urandom_range(0, 3));
            end
        endcase
        return f;
    endfunction

    function automatic s_word_t pack_frame(frame_t f);
        s_word_t w;
        w = '0;
        for (int i = 0; i < PORT_CHANNELS; i++)
            w[i*PORT_POWER_BITS +: PORT_POWER_BITS] = f.power[i];
        w[S_LOCK_BIT] = f.lockout;
        w[S_CLEAR_BIT] = f.clear;
        return w;
    endfunction

    task automatic send_frame(frame_t f, bit known, report_t want);
        int gap;
        report_t predicted;
        gap = send_gaps_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            @(negedge clk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= pack_frame(f);
        do
            @(posedge clk);
        while (!s_tready);
        predicted = judge_frame(f);
        pending_reports.push_back(known ? want : predicted);
    endtask

    task automatic drop_input();
        @(negedge clk) s_tvalid <= 1'b0;
    endtask

    task automatic set_gain(bit [7:0] value);
        while (pending_reports.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        gain = value;
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // Result side: draws a stall per word and checks each word on arrival.
    initial
    begin
        int      hold;
        m_word_t w;
        report_t got;
        report_t want;
        wait (rst_n);
        forever
        begin
            hold = recv_gaps_on ? $urandom_range(0, 12) : 0;
            if (hold_off_pending)
            begin
                hold = HOLD_OFF_CYCLES;
                hold_off_pending = 1'b0;
            end
            if (hold > 0)
            begin
                @(negedge clk) m_tready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk) m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            w = m_tdata;
            got.hit_now = w[M_HIT_NOW_BIT];
            got.hit_flag = w[M_HIT_FLAG_BIT];
            got.max_channel = w[M_CH_LSB +: CH_IDX_BITS];
            got.max_channel_count = w[M_COUNT_LSB +: COUNT_BITS];
            got.median_power = w[M_MEDIAN_LSB +: PORT_POWER_BITS];
            if (pending_reports.size() == 0)
            begin
                $error("result word arrived with no frame pending");
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.hit_now != want.hit_now)
                begin
                    $error("hit_now: expected %0d, got %0d", want.hit_now, got.hit_now);
                    mismatches++;
                end
                if (got.hit_flag != want.hit_flag)
                begin
                    $error("hit_flag: expected %0d, got %0d", want.hit_flag, got.hit_flag);
                    mismatches++;
                end
                if (got.max_channel != want.max_channel)
                begin
                    $error("max_channel: expected %0d, got %0d",
                           want.max_channel, got.max_channel);
                    mismatches++;
                end
                if (got.max_channel_count != want.max_channel_count)
                begin
                    $error("max_channel_count: expected %0d, got %0d",
                           want.max_channel_count, got.max_channel_count);
                    mismatches++;
                end
                if (got.median_power != want.median_power)
                begin
                    $error("median_power: expected %0h, got %0h",
                           want.median_power, got.median_power);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        row_t    directed_rows [14];
        report_t none;
        frame_t  f;
        bit [7:0] phase_gain;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet_cycles = 0;
        mismatches = 0;
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        hold_off_pending = 1'b0;
        gain = FACTOR_RESET;
        sticky_flag = 1'b0;
        for (int i = 0; i < PORT_CHANNELS; i++)
            chan_hits[i] = '0;
        none = '{1'b0, 1'b0, 4'd0, 16'd0, 32'd0};

        // The first rows run under the reset factor of five.
        directed_rows = '{
            row(flat_frame(32'd0, 0, 32'd0, 0, 32'd0, 1'b0, 1'b0), 1'b1,
                '{1'b0, 1'b0, 4'd0, 16'd0, 32'd0}),
            row(flat_frame(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1'b0, 1'b0),
                1'b1, '{1'b0, 1'b0, 4'd0, 16'd0, 32'hFFFF_FFFF}),
            row(flat_frame(32'd1, 9, 32'd100, 9, 32'd100, 1'b0, 1'b0), 1'b1,
                '{1'b1, 1'b1, 4'd9, 16'd1, 32'd1}),
            row(flat_frame(32'd1, 9, 32'd100, 9, 32'd100, 1'b1, 1'b0), 1'b1,
                '{1'b0, 1'b1, 4'd9, 16'd1, 32'd1}),
            row(flat_frame(32'd1, 9, 32'd100, 9, 32'd100, 1'b1, 1'b1), 1'b1,
                '{1'b0, 1'b0, 4'd9, 16'd1, 32'd1}),
            row(flat_frame(32'd1, 9, 32'd100, 9, 32'd100, 1'b0, 1'b1), 1'b1,
                '{1'b1, 1'b1, 4'd9, 16'd2, 32'd1}),
            row(flat_frame(32'd10, 3, 32'd1000, 7, 32'd1000, 1'b0, 1'b0), 1'b0, none),
            row(flat_frame(32'd10, 5, 32'd50, 5, 32'd50, 1'b0, 1'b0), 1'b0, none),
            row(flat_frame(32'd10, 5, 32'd51, 5, 32'd51, 1'b0, 1'b0), 1'b0, none),
            row(flat_frame(32'd0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1'b0, 1'b0), 1'b0, none),
            row(flat_frame(32'hAAAA_AAAA, 2, 32'h5555_5555, 2, 32'h5555_5555, 1'b0, 1'b1),
                1'b0, none),
            row(flat_frame(32'h5555_5555, 8, 32'hFFFF_FFFF, 8, 32'hFFFF_FFFF, 1'b0, 1'b0),
                1'b0, none),
            row(flat_frame(32'h3333_3333, 1, 32'hFFFF_FFFF, 6, 32'hFFFF_FFFF, 1'b1, 1'b0),
                1'b0, none),
            row(flat_frame(32'h7FFF_FFFF, 4, 32'h8000_0000, 4, 32'h8000_0000, 1'b0, 1'b0),
                1'b0, none)
        };

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_frame(directed_rows[i].frame, directed_rows[i].known, directed_rows[i].want);
        drop_input();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: phase_gain = 8'd1;
                1: phase_gain = 8'd255;
                2: phase_gain = 8'd0;
                7: phase_gain = FACTOR_RESET;
                default: phase_gain = 8'($urandom_range(2, 254));
            endcase
            set_gain(phase_gain);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 30 == 0)
                begin
                    send_gaps_on = ($urandom_range(0, 3) != 0);
                    recv_gaps_on = ($urandom_range(0, 3) != 0);
                    if (k == 0 && p == 1)
                    begin
                        send_gaps_on = 1'b0;
                        hold_off_pending = 1'b1;
                    end
                end
                send_frame(draw_frame(), 1'b0, none);
            end
            drop_input();
        end

        // A streak of back-to-back hits that all land on one channel.
        set_gain(8'd1);
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
        repeat (STREAK_ITEMS)
        begin
            for (int i = 0; i < PORT_CHANNELS; i++)
                f.power[i] = $urandom_range(0, 32'h7FFF_FFFF);
            f.power[SAT_CHANNEL] = 32'h8000_0000 | $urandom;
            f.lockout = 1'b0;
            f.clear = ($urandom_range(0, 7) == 0);
            send_frame(f, 1'b0, none);
        end
        drop_input();

        set_gain(FACTOR_RESET);
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        repeat (40)
            send_frame(draw_frame(), 1'b0, none);
        drop_input();

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
